>>> design/lss_pkg.sv
// Package: types, constants and codes for the lottery slot scheduler.
`timescale 1ns / 1ps
package lss_pkg;
    localparam int SLOTS_DEF  = 32;
    localparam int QUEUES_DEF = 16;
    localparam logic [3:0] PRIO_DRAW   = 4'd13;
    localparam logic [3:0] PRIO_PARKED = 4'd14;
    localparam logic [3:0] PRIO_WON    = 4'd12;
    localparam logic [7:0] START_TICKETS = 8'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_PRIO = 2'd2;

    localparam logic [1:0] CFG_DYN = 2'd0;
    localparam logic [1:0] CFG_MAX = 2'd1;
    localparam logic [1:0] CFG_MIN = 2'd2;

    typedef enum logic [2:0] {
        ACT_START = 3'd0, ACT_STOP = 3'd1, ACT_EXPIRE = 3'd2, ACT_TICKETS = 3'd3,
        ACT_MARK = 3'd4, ACT_MAXPRIO = 3'd5, ACT_AGE = 3'd6, ACT_NOP = 3'd7
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SUM, S_MOD, S_WALK, S_AGE, S_OUT
    } t_state;
endpackage

>>> design/lss_if.sv
// Valid/ready channel interfaces for input actions and results.
`timescale 1ns / 1ps
interface lss_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [4:0]  slot;
    logic [7:0]  value;
    logic [30:0] random_word;
    modport source (output valid, action, slot, value, random_word, input ready);
    modport sink (input valid, action, slot, value, random_word, output ready);
endinterface

interface lss_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] slot_priority;
    logic [7:0] slot_tickets;
    logic       winner_found;
    logic [4:0] winner_slot;
    modport source (output valid, status, slot_priority, slot_tickets, winner_found,
        winner_slot, input ready);
    modport sink (input valid, status, slot_priority, slot_tickets, winner_found,
        winner_slot, output ready);
endinterface

>>> design/lss_divmod.sv
// Restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
module lss_divmod #(
    parameter int NW = 31,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_rem
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_num;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   w_sh;

    assign w_sh = {r_rem[DW-1:0], r_num[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= (w_sh >= {1'b0, r_den}) ? w_sh - {1'b0, r_den} : w_sh;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end
    assign o_done = r_busy && (r_cnt == CW'(1));
    assign o_rem  = (w_sh >= {1'b0, r_den}) ? DW'(w_sh - {1'b0, r_den}) : DW'(w_sh);
endmodule

>>> design/lottery_slot_scheduler.sv
// Top level of the lottery slot scheduler: slot table, sequencer and lottery walk.
`timescale 1ns / 1ps
// One action is taken at a time. A plain slot action passes through the execute
// and output states before its result is registered. An aging tick visits every
// slot, one per cycle. A lottery walks the table twice, one slot per cycle, with
// a bit-serial remainder between the walks: the first walk sums the tickets and
// the second subtracts them. Per-slot fields live in flip-flops with in-use and
// marked flags cleared at reset; priority, maximum priority and tickets are
// undefined until a start writes them. The result sits in an output register until
// taken; the next action is accepted only once that register has been cleared.
module lottery_slot_scheduler
    import lss_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int QUEUES = QUEUES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    lss_in_if.sink    in_ch,
    lss_out_if.source out_ch
);
    localparam int IW = $clog2(SLOTS);
    localparam int TW = $clog2(SLOTS * 255 + 1);

    logic       r_dyn;
    logic [7:0] r_maxt, r_mint;

    logic [SLOTS-1:0] r_used, r_mark;
    logic [3:0] r_prio [SLOTS];
    logic [3:0] r_maxp [SLOTS];
    logic [7:0] r_tix  [SLOTS];

    t_state r_state, n_state;
    t_action   r_act;
    logic [4:0]  r_slot;
    logic [7:0]  r_val;
    logic [30:0] r_rnd;
    logic [IW-1:0] r_idx;
    logic [TW-1:0] r_acc;
    logic [TW:0]   r_left;
    logic          r_found;
    logic [IW-1:0] r_won;

    logic       r_ovalid;
    logic [1:0] r_status;
    logic [3:0] r_oprio;
    logic [7:0] r_otix;
    logic       r_ofound;
    logic [4:0] r_owin;

    logic w_ok;
    logic [IW-1:0] w_s;
    logic w_last;
    logic w_div_start, w_div_done;
    logic [TW-1:0] w_rem;
    logic [TW:0] w_sub;
    logic w_draw_elig;

    assign w_ok   = 32'(r_slot) < SLOTS;
    assign w_s    = IW'(r_slot);
    assign w_last = r_idx == IW'(SLOTS - 1);
    assign w_draw_elig = r_used[r_idx] && !r_mark[r_idx] && r_prio[r_idx] == PRIO_DRAW;
    assign w_sub  = r_left - {{(TW-7){1'b0}}, r_tix[r_idx]};

    assign in_ch.ready = (r_state == S_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn <= 1'b0; r_maxt <= 8'd10; r_mint <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DYN: r_dyn  <= i_cfg_data[0];
                CFG_MAX: r_maxt <= i_cfg_data;
                CFG_MIN: r_mint <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lss_divmod #(.NW(31), .DW(TW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(r_rnd), .i_den(r_acc), .o_done(w_div_done), .o_rem(w_rem)
    );

    always_comb begin
        n_state = r_state;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE:  if (in_ch.valid && in_ch.ready) n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_OUT;
                if (r_act == ACT_AGE) n_state = S_AGE;
                else if (w_ok && r_used[w_s]) begin
                    if (r_act == ACT_STOP) n_state = S_SUM;
                    else if (r_act == ACT_EXPIRE &&
                        (r_prio[w_s] == PRIO_DRAW || r_prio[w_s] == PRIO_WON))
                        n_state = S_SUM;
                end
            end
            S_SUM: if (w_last) begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (r_acc == '0) n_state = S_OUT;
                else if (w_div_done) n_state = S_WALK;
                w_div_start = (r_acc != '0) && (r_idx == '0) && !r_found && r_left == '0;
            end
            S_WALK:  if (w_last) n_state = S_OUT;
            S_AGE:   if (w_last) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Expiry pre-check: 12 becomes 13 after the step, 13 stays; both draw.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; r_mark <= '0; r_ovalid <= 1'b0;
            r_idx <= '0; r_acc <= '0; r_left <= '0; r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && out_ch.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (in_ch.valid && in_ch.ready) begin
                    r_act  <= t_action'(in_ch.action);
                    r_slot <= in_ch.slot;
                    r_val  <= in_ch.value;
                    r_rnd  <= in_ch.random_word;
                    r_status <= ST_OK; r_found <= 1'b0; r_won <= '0;
                    r_idx <= '0; r_acc <= '0; r_left <= '0;
                end
                S_EXEC: begin
                    if (r_act == ACT_AGE || r_act == ACT_NOP) r_status <= ST_OK;
                    else if (!w_ok) r_status <= ST_BAD;
                    else if (r_act == ACT_START) begin
                        if (r_used[w_s]) r_status <= ST_BAD;
                        else if (32'(r_val) >= QUEUES) r_status <= ST_PRIO;
                        else begin
                            r_maxp[w_s] <= r_val[3:0]; r_prio[w_s] <= r_val[3:0];
                            r_tix[w_s] <= START_TICKETS;
                            r_mark[w_s] <= 1'b0; r_used[w_s] <= 1'b1;
                        end
                    end else if (!r_used[w_s]) r_status <= ST_BAD;
                    else begin
                        case (r_act)
                            ACT_STOP: r_used[w_s] <= 1'b0;
                            ACT_EXPIRE: begin
                                if (r_dyn && r_prio[w_s] == PRIO_WON && r_tix[w_s] > r_mint)
                                    r_tix[w_s] <= r_tix[w_s] - 8'd1;
                                if (r_dyn && r_prio[w_s] == PRIO_DRAW && r_tix[w_s] < r_maxt)
                                    r_tix[w_s] <= r_tix[w_s] + 8'd1;
                                if (r_prio[w_s] < PRIO_DRAW) r_prio[w_s] <= r_prio[w_s] + 4'd1;
                            end
                            ACT_TICKETS: begin
                                if (r_val > r_maxt)
                                    r_tix[w_s] <= (r_maxt < r_mint) ? r_mint : r_maxt;
                                else r_tix[w_s] <= (r_val < r_mint) ? r_mint : r_val;
                            end
                            ACT_MARK: r_mark[w_s] <= r_val != 8'd0;
                            ACT_MAXPRIO: begin
                                if (32'(r_val) >= QUEUES) r_status <= ST_PRIO;
                                else begin
                                    r_maxp[w_s] <= r_val[3:0]; r_prio[w_s] <= r_val[3:0];
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SUM: begin
                    if (r_used[r_idx] && r_mark[r_idx]) r_prio[r_idx] <= PRIO_PARKED;
                    if (w_draw_elig) r_acc <= r_acc + TW'(r_tix[r_idx]);
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                end
                S_MOD: if (w_div_start) r_left <= {1'b0, {TW{1'b1}}};
                    else if (w_div_done) r_left <= {1'b0, w_rem} + 1'b1;
                S_WALK: begin
                    if (w_draw_elig && !r_left[TW] && r_left != '0) begin
                        r_left <= w_sub;
                        if (w_sub[TW] || w_sub == '0) begin
                            r_prio[r_idx] <= PRIO_WON; r_found <= 1'b1; r_won <= r_idx;
                        end
                    end
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                end
                S_AGE: begin
                    if (r_used[r_idx] && r_prio[r_idx] > r_maxp[r_idx])
                        r_prio[r_idx] <= r_prio[r_idx] - 4'd1;
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_ofound <= r_found;
                    r_owin   <= r_found ? 5'(r_won) : 5'd0;
                    if (w_ok && r_used[w_s]) begin
                        r_oprio <= r_prio[w_s]; r_otix <= r_tix[w_s];
                    end else begin
                        r_oprio <= '0; r_otix <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_ch.valid         = r_ovalid;
    assign out_ch.status        = r_status;
    assign out_ch.slot_priority = r_oprio;
    assign out_ch.slot_tickets  = r_otix;
    assign out_ch.winner_found  = r_ofound;
    assign out_ch.winner_slot   = r_owin;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT)) else $error("stray result");
    a_winner_implies_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_acc == '0) |-> 1'b0) else $error("walk without tickets");
endmodule

>>> sim/lss_checker.sv
// Checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
module lss_checker
    import lss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    lss_in_if         in_ch,
    lss_out_if        out_ch,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_wins_seen,
    output int        o_results_seen
);
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] prio;
        logic [7:0] tickets;
        logic       found;
        logic [4:0] winner;
    } t_result;

    logic       dyn_mode;
    logic [7:0] tick_max;
    logic [7:0] tick_min;
    logic       used   [SLOTS_DEF];
    logic       marked [SLOTS_DEF];
    logic [3:0] prio   [SLOTS_DEF];
    logic [3:0] maxp   [SLOTS_DEF];
    logic [7:0] tix    [SLOTS_DEF];
    t_result    expected_q[$];

    // ticket-weighted draw among unmarked priority-13 slots; marked slots park at 14
    function automatic logic hold_lottery(input logic [30:0] rnd, output logic [4:0] won);
        int unsigned total;
        longint      left;
        logic        got;
        total = 0;
        got   = 1'b0;
        won   = '0;
        for (int i = 0; i < SLOTS_DEF; i++) begin
            if (used[i]) begin
                if (marked[i]) prio[i] = PRIO_PARKED;
                else if (prio[i] == PRIO_DRAW) total += tix[i];
            end
        end
        if (total == 0) return 1'b0;
        left = longint'(rnd % total) + 1;
        for (int i = 0; i < SLOTS_DEF; i++) begin
            if (used[i] && !marked[i] && prio[i] == PRIO_DRAW && left > 0) begin
                left -= tix[i];
                if (left <= 0) begin
                    prio[i] = PRIO_WON;
                    won     = i[4:0];
                    got     = 1'b1;
                end
            end
        end
        return got;
    endfunction

    function automatic t_result schedule_action(input t_action act, input logic [4:0] s,
                                                input logic [7:0] v, input logic [30:0] rnd);
        t_result r;
        logic [7:0] t;
        r = '0;
        if (act == ACT_AGE) begin
            for (int i = 0; i < SLOTS_DEF; i++)
                if (used[i] && prio[i] > maxp[i]) prio[i]--;
        end else if (act == ACT_NOP) begin
        end else if (act == ACT_START) begin
            if (used[s]) r.status = ST_BAD;
            else if (v >= QUEUES_DEF) r.status = ST_PRIO;
            else begin
                maxp[s] = v[3:0]; prio[s] = v[3:0]; tix[s] = START_TICKETS;
                marked[s] = 1'b0; used[s] = 1'b1;
            end
        end else if (!used[s]) begin
            r.status = ST_BAD;
        end else begin
            case (act)
                ACT_STOP: begin
                    used[s] = 1'b0;
                    r.found = hold_lottery(rnd, r.winner);
                end
                ACT_EXPIRE: begin
                    if (dyn_mode) begin
                        if (prio[s] == PRIO_WON && tix[s] > tick_min) tix[s]--;
                        else if (prio[s] == PRIO_DRAW && tix[s] < tick_max) tix[s]++;
                    end
                    if (prio[s] < PRIO_DRAW) prio[s]++;
                    if (prio[s] == PRIO_DRAW) r.found = hold_lottery(rnd, r.winner);
                end
                ACT_TICKETS: begin
                    t = v;
                    if (t > tick_max) t = tick_max;
                    if (t < tick_min) t = tick_min;
                    tix[s] = t;
                end
                ACT_MARK: marked[s] = (v != 0);
                default: begin
                    if (v >= QUEUES_DEF) r.status = ST_PRIO;
                    else begin
                        maxp[s] = v[3:0]; prio[s] = v[3:0];
                    end
                end
            endcase
        end
        if (!r.found) r.winner = '0;
        if (used[s]) begin
            r.prio    = prio[s];
            r.tickets = tix[s];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            dyn_mode <= 1'b0;
            tick_max <= 8'd10;
            tick_min <= 8'd1;
            for (int i = 0; i < SLOTS_DEF; i++) begin
                used[i]   = 1'b0;
                marked[i] = 1'b0;
                prio[i]   = '0;
                maxp[i]   = '0;
                tix[i]    = '0;
            end
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DYN: dyn_mode <= i_cfg_data[0];
                    CFG_MAX: tick_max <= i_cfg_data;
                    CFG_MIN: tick_min <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                o_results_seen++;
                if (expected_q.size() == 0) begin
                    $display("[%0t] result transaction with nothing expected", $realtime);
                    o_fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (out_ch.status !== exp_r.status)
                        report_mismatch("status", out_ch.status, exp_r.status);
                    if (out_ch.slot_priority !== exp_r.prio)
                        report_mismatch("slot_priority", out_ch.slot_priority, exp_r.prio);
                    if (out_ch.slot_tickets !== exp_r.tickets)
                        report_mismatch("slot_tickets", out_ch.slot_tickets, exp_r.tickets);
                    if (out_ch.winner_found !== exp_r.found)
                        report_mismatch("winner_found", out_ch.winner_found, exp_r.found);
                    if (out_ch.winner_slot !== exp_r.winner)
                        report_mismatch("winner_slot", out_ch.winner_slot, exp_r.winner);
                    if (exp_r.found) o_wins_seen++;
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(schedule_action(t_action'(in_ch.action), in_ch.slot,
                                                     in_ch.value, in_ch.random_word));
        end
    end

    initial begin
        o_fail_count   = 0;
        o_wins_seen    = 0;
        o_results_seen = 0;
    end
endmodule

>>> sim/testbench.sv
// Testbench top: clock, reset, register setup, action stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import lss_pkg::*;

    localparam int DRAIN_CYCLES = 200;     // longer than a lottery
    localparam int CYCLE_LIMIT  = 2000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    int         fail_count;
    int         pending;
    int         wins_seen;
    int         results_seen;
    int         cycle_count;
    int         actions_sent;
    int         out_hold;

    // local mirror of which slots are in use, steering toward legal actions
    logic       live [SLOTS_DEF];

    lss_in_if  in_ch ();
    lss_out_if out_ch ();

    lottery_slot_scheduler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source)
    );

    lss_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_wins_seen   (wins_seen),
        .o_results_seen(results_seen)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one, sometimes none at all
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result-side backpressure: ready drops for a random number of cycles after a take
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_hold     <= 0;
        end else if (out_ch.ready && out_ch.valid) begin
            g = pick_gap();
            out_hold     <= g;
            out_ch.ready <= (g == 0);
        end else if (!out_ch.ready) begin
            if (out_hold > 1) out_hold <= out_hold - 1;
            else out_ch.ready <= 1'b1;
        end
    end

    // valid stays up after a transaction until the next gap or an idle wait drops it
    task automatic send_action(input t_action act, input logic [4:0] s, input logic [7:0] v,
                               input logic [30:0] rnd);
        int g;
        g = pick_gap();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.slot        <= s;
        in_ch.value       <= v;
        in_ch.random_word <= rnd;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        actions_sent++;
        if (act == ACT_START && !live[s] && v < QUEUES_DEF) live[s] = 1'b1;
        else if (act == ACT_STOP) live[s] = 1'b0;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [4:0] pick_slot(input logic want_live);
        logic [4:0] s;
        for (int k = 0; k < 8; k++) begin
            s = 5'($urandom_range(0, SLOTS_DEF - 1));
            if (live[s] == want_live) return s;
        end
        return s;
    endfunction

    // one random action, weighted toward legal moves on a moderately full table
    task automatic random_action();
        int         r;
        logic [4:0] s;
        logic [7:0] v;
        logic [30:0] rnd;
        r   = $urandom_range(0, 99);
        rnd = 31'($urandom);
        v   = 8'($urandom_range(0, 255));
        if (r < 18) begin
            s = pick_slot(1'b0);
            send_action(ACT_START, s,
                        ($urandom_range(0, 9) == 0) ? v : 8'($urandom_range(10, 15)), rnd);
        end else if (r < 28) begin
            send_action(ACT_STOP, pick_slot(1'b1), v, rnd);
        end else if (r < 58) begin
            send_action(ACT_EXPIRE, pick_slot(1'b1), v, rnd);
        end else if (r < 68) begin
            send_action(ACT_TICKETS, pick_slot(1'b1), v, rnd);
        end else if (r < 76) begin
            send_action(ACT_MARK, pick_slot(1'b1),
                        ($urandom_range(0, 2) == 0) ? v : 8'd0, rnd);
        end else if (r < 84) begin
            send_action(ACT_MAXPRIO, pick_slot(1'b1),
                        ($urandom_range(0, 7) == 0) ? v : 8'($urandom_range(9, 15)), rnd);
        end else if (r < 92) begin
            send_action(ACT_AGE, 5'($urandom), v, rnd);
        end else begin
            // noise: any code on any slot, the idle code included
            send_action(t_action'($urandom_range(0, 7)), 5'($urandom), v, rnd);
        end
    endtask

    initial begin
        int lim_wait;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_NOP;
        in_ch.slot        = '0;
        in_ch.value       = '0;
        in_ch.random_word = '0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_DYN;
        cfg_data          = '0;
        i_rst_n           = 1'b0;
        cycle_count       = 0;
        actions_sent      = 0;
        for (int i = 0; i < SLOTS_DEF; i++) live[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, field extremes, error codes, lottery paths
        send_action(ACT_STOP, 5'd0, 8'd0, 31'd0);              // free slot -> bad state
        send_action(ACT_START, 5'd31, 8'd255, 31'h7fffffff);   // priority out of range
        send_action(ACT_START, 5'd31, 8'd12, 31'd0);
        send_action(ACT_START, 5'd31, 8'd12, 31'd0);           // already in use
        send_action(ACT_START, 5'd0, 8'd13, 31'd0);
        send_action(ACT_START, 5'd1, 8'd0, 31'd0);
        send_action(ACT_TICKETS, 5'd0, 8'd255, 31'd0);         // clamp to max
        send_action(ACT_TICKETS, 5'd1, 8'd0, 31'd0);           // clamp to min
        send_action(ACT_EXPIRE, 5'd31, 8'd0, 31'h7fffffff);    // 12 -> 13, lottery
        send_action(ACT_MARK, 5'd1, 8'd128, 31'd0);
        send_action(ACT_STOP, 5'd0, 8'd0, 31'h2aaaaaaa);       // lottery, parks marked
        send_action(ACT_MAXPRIO, 5'd1, 8'd16, 31'd0);
        send_action(ACT_MAXPRIO, 5'd1, 8'd0, 31'd0);
        send_action(ACT_AGE, 5'd31, 8'd0, 31'd0);
        send_action(ACT_MARK, 5'd1, 8'd0, 31'd0);
        send_action(ACT_NOP, 5'd7, 8'd85, 31'h55555555);
        send_action(ACT_EXPIRE, 5'd31, 8'd0, 31'd1);           // 12 -> 13, lottery
        wait_idle();

        // dynamic ticket adjustment, min equal to max
        write_reg(CFG_DYN, 8'd1);
        write_reg(CFG_MAX, 8'd255);
        write_reg(CFG_MIN, 8'd255);
        send_action(ACT_TICKETS, 5'd31, 8'd3, 31'd0);
        send_action(ACT_EXPIRE, 5'd31, 8'd0, 31'd77);
        wait_idle();
        write_reg(CFG_MIN, 8'd1);
        write_reg(CFG_MAX, 8'd1);
        wait_idle();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_DYN, 8'd1); write_reg(CFG_MAX, 8'd10);
                         write_reg(CFG_MIN, 8'd1); end
                1: begin write_reg(CFG_DYN, 8'd0); write_reg(CFG_MAX, 8'd255);
                         write_reg(CFG_MIN, 8'd1); end
                2: begin write_reg(CFG_DYN, 8'd1); write_reg(CFG_MAX, 8'd1);
                         write_reg(CFG_MIN, 8'd255); end
                3: begin write_reg(CFG_DYN, 8'd1); write_reg(CFG_MAX, 8'd255);
                         write_reg(CFG_MIN, 8'd255); end
                4: begin write_reg(CFG_DYN, 8'd1); write_reg(CFG_MAX, 8'($urandom_range(1, 255)));
                         write_reg(CFG_MIN, 8'($urandom_range(1, 40))); end
                default: begin write_reg(CFG_DYN, 8'd1); write_reg(CFG_MAX, 8'd6);
                         write_reg(CFG_MIN, 8'd4); end
            endcase
            for (int n = 0; n < 240; n++) begin
                random_action();
                // hold off the sender until the block has drained
                if (n == 120) wait_idle();
            end
            wait_idle();
        end

        lim_wait = 0;
        while (pending != 0 && lim_wait < 100000) begin
            @(posedge i_clk);
            lim_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d actions, %0d results, %0d lottery winners", actions_sent,
                 results_seen, wins_seen);
        $display("register settings: reset values, dynamic on/off, clamps at 1 and 255");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
